// ===== sv/vector3_arithmetic_unit_top_assert.svh =====
// ----------------------------------------------------------------------------
// Vector ALU assertion macros
// Shared concurrent checks for the vector arithmetic unit.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define VECTOR3_ARITHMETIC_UNIT_TOP_ASSERT_SVH

// check that a condition implies a consequence on the same clock edge
`define V3A_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// check that a condition implies a consequence on the next clock edge
`define V3A_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/v3a_pkg.sv =====
// ----------------------------------------------------------------------------
// Vector ALU package
// Widths, operation codes, pipeline depth and saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package v3a_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits  = 16;
  localparam int ProdWidth = 2 * DataWidth;
  localparam int SumWidth  = ProdWidth + 2;
  localparam int SqWidth   = ProdWidth + 2;
  localparam int RootWidth = SqWidth / 2;
  localparam int NumWidth  = DataWidth + FracBits;
  localparam int QuoWidth  = NumWidth;
  localparam int OpWidth   = 3;

  // pipeline: 1 product, 1 sum, 1 root load, RootWidth sqrt steps, 1 div load,
  // QuoWidth div steps; the output register follows
  localparam int PipeDepth = RootWidth + QuoWidth + 4;

  typedef enum logic [OpWidth-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_NEG = 3'd2,
    OP_SCL = 3'd3,
    OP_DOT = 3'd4,
    OP_CRS = 3'd5,
    OP_MAG = 3'd6,
    OP_NRM = 3'd7
  } op_e;

  typedef logic signed [DataWidth-1:0] data_t;
  typedef logic signed [ProdWidth-1:0] prod_t;
  typedef logic signed [SumWidth-1:0]  sum_t;

  typedef struct packed {
    op_e                  op;
    data_t                a;
    data_t                r;
    logic                 ov;
    logic [SqWidth-1:0]   sq;
  } lane_ctl_t;

  localparam logic signed [SumWidth-1:0] SatHi =
    SumWidth'({1'b0, {(DataWidth-1){1'b1}}});
  localparam logic signed [SumWidth-1:0] SatLo = -SatHi - SumWidth'(1);

  function automatic data_t sat_sum(input sum_t v, output logic ov);
    begin
      ov = 1'b0;
      if (v > SatHi) begin
        ov = 1'b1;
        sat_sum = DataWidth'(SatHi);
      end else if (v < SatLo) begin
        ov = 1'b1;
        sat_sum = DataWidth'(SatLo);
      end else begin
        sat_sum = DataWidth'(v);
      end
    end
  endfunction

  // round half up: (v + 2^(F-1)) >>> F
  function automatic sum_t round_frac(input sum_t v);
    sum_t t;
    begin
      t = v + (SumWidth'(1) <<< (FracBits - 1));
      round_frac = t >>> FracBits;
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/v3a_lane.sv =====
// ----------------------------------------------------------------------------
// Vector ALU lane
// One component: add, sub, negate, products, then a serial-step divider for
// normalize. Each stage is one register of a pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module v3a_lane
  import v3a_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 adv_i,
  input  wire op_e                  op_i,
  input  wire data_t                a_i,
  input  wire data_t                b_i,
  input  wire data_t                c_i,
  input  wire data_t                d_i,
  input  wire data_t                f_i,
  input  wire data_t                g_i,
  input  wire logic [RootWidth-1:0] m_i,
  input  wire logic                 m_vld_i,
  output prod_t                     p0_o,
  output prod_t                     p1_o,
  output data_t                     r_o,
  output logic                      ov_o
);

  // stage 1: elementwise ops and products
  op_e   op1_q;
  data_t a1_q;
  data_t r1_q;
  logic  ov1_q;
  prod_t p0_q, p1_q;

  logic signed [DataWidth:0] s_w;
  data_t                     r1_d;
  logic                      ov1_d;
  prod_t                     pc_w;
  prod_t                     pf_w;

  assign pc_w = c_i * d_i;
  assign pf_w = f_i * g_i;

  always_comb begin
    s_w = '0;
    case (op_i)
      OP_ADD:  s_w = {a_i[DataWidth-1], a_i} + {b_i[DataWidth-1], b_i};
      OP_SUB:  s_w = {a_i[DataWidth-1], a_i} - {b_i[DataWidth-1], b_i};
      OP_NEG:  s_w = -{a_i[DataWidth-1], a_i};
      default: s_w = '0;
    endcase
    r1_d  = sat_sum(SumWidth'(s_w), ov1_d);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      op1_q <= op_i;
      a1_q  <= a_i;
      r1_q  <= r1_d;
      ov1_q <= ov1_d;
      p0_q  <= (op_i == OP_SCL) ? pf_w : pc_w;
      p1_q  <= pf_w;
    end
  end

  assign p0_o = p0_q;
  assign p1_o = p1_q;

  // stage 2: scale and cross results
  op_e   op2_q;
  data_t a2_q;
  data_t r2_q;
  logic  ov2_q;
  data_t r2_d;
  logic  ov2_d;
  data_t rs_w;
  logic  ovs_w;

  always_comb begin
    rs_w = sat_sum(round_frac(SumWidth'(p0_q)), ovs_w);
    r2_d  = r1_q;
    ov2_d = ov1_q;
    if (op1_q == OP_SCL) begin
      r2_d  = rs_w;
      ov2_d = ovs_w;
    end else if (op1_q == OP_CRS) begin
      r2_d  = sat_sum(round_frac(SumWidth'(p0_q) - SumWidth'(p1_q)), ov2_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      op2_q <= op1_q;
      a2_q  <= a1_q;
      r2_q  <= r2_d;
      ov2_q <= ov2_d;
    end
  end

  // delay line to the point where m is known
  localparam int DlyDepth = RootWidth + 1;
  op_e   dop_q [DlyDepth];
  data_t da_q  [DlyDepth];
  data_t dr_q  [DlyDepth];
  logic  dov_q [DlyDepth];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dop_q[0] <= op2_q;
      da_q[0]  <= a2_q;
      dr_q[0]  <= r2_q;
      dov_q[0] <= ov2_q;
      for (int i = 1; i < DlyDepth; i++) begin
        dop_q[i] <= dop_q[i-1];
        da_q[i]  <= da_q[i-1];
        dr_q[i]  <= dr_q[i-1];
        dov_q[i] <= dov_q[i-1];
      end
    end
  end

  // restoring divider, one quotient bit per stage
  localparam int RemWidth = RootWidth + 1;
  logic [NumWidth-1:0]  dn_q  [QuoWidth+1];
  logic [QuoWidth-1:0]  dq_q  [QuoWidth+1];
  logic [RemWidth-1:0]  drm_q [QuoWidth+1];
  logic [RootWidth-1:0] dm_q  [QuoWidth+1];
  op_e                  xop_q [QuoWidth+1];
  logic                 xng_q [QuoWidth+1];
  data_t                xr_q  [QuoWidth+1];
  logic                 xov_q [QuoWidth+1];
  logic                 xz_q  [QuoWidth+1];

  logic [DataWidth-1:0] absa_w;
  assign absa_w = da_q[DlyDepth-1][DataWidth-1] ?
                  DataWidth'(-da_q[DlyDepth-1]) : da_q[DlyDepth-1];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dn_q[0]  <= {absa_w, {FracBits{1'b0}}} ;
      dq_q[0]  <= '0;
      drm_q[0] <= '0;
      dm_q[0]  <= m_i;
      xop_q[0] <= dop_q[DlyDepth-1];
      xng_q[0] <= da_q[DlyDepth-1][DataWidth-1];
      xr_q[0]  <= dr_q[DlyDepth-1];
      xov_q[0] <= dov_q[DlyDepth-1];
      xz_q[0]  <= !m_vld_i;
    end
  end

  for (genvar k = 0; k < QuoWidth; k++) begin : g_div
    logic [RemWidth:0] t_w;
    assign t_w = {drm_q[k], dn_q[k][NumWidth-1]};
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        dn_q[k+1]  <= dn_q[k] << 1;
        if (t_w >= {1'b0, 1'b0, dm_q[k]}) begin
          drm_q[k+1] <= RemWidth'(t_w - {2'b0, dm_q[k]});
          dq_q[k+1]  <= {dq_q[k][QuoWidth-2:0], 1'b1};
        end else begin
          drm_q[k+1] <= RemWidth'(t_w);
          dq_q[k+1]  <= {dq_q[k][QuoWidth-2:0], 1'b0};
        end
        dm_q[k+1]  <= dm_q[k];
        xop_q[k+1] <= xop_q[k];
        xng_q[k+1] <= xng_q[k];
        xr_q[k+1]  <= xr_q[k];
        xov_q[k+1] <= xov_q[k];
        xz_q[k+1]  <= xz_q[k];
      end
    end
  end

  // round: q+1 when 2*rem >= m (ties away from zero equals (num+m/2)/m)
  logic [QuoWidth:0]      qr_w;
  logic signed [SumWidth-1:0] qv_w;
  logic [RemWidth:0]      r2x_w;
  logic [RootWidth-1:0]   mf_w;
  data_t                  rn_w;
  logic                   ovn_w;

  always_comb begin
    mf_w  = dm_q[QuoWidth];
    r2x_w = {drm_q[QuoWidth], 1'b0};
    qr_w  = {1'b0, dq_q[QuoWidth]};
    if (r2x_w >= {2'b0, mf_w} + {2'b0, mf_w[0]}) begin
      qr_w = qr_w + 1'b1;
    end
    qv_w  = xng_q[QuoWidth] ? -SumWidth'(qr_w) : SumWidth'(qr_w);
    rn_w  = sat_sum(qv_w, ovn_w);
    r_o   = xr_q[QuoWidth];
    ov_o  = xov_q[QuoWidth];
    if (xop_q[QuoWidth] == OP_NRM) begin
      r_o  = xz_q[QuoWidth] ? '0 : rn_w;
      ov_o = xz_q[QuoWidth] ? 1'b0 : ovn_w;
    end
  end

endmodule

`default_nettype wire

// ===== sv/v3a_merge.sv =====
// ----------------------------------------------------------------------------
// Vector ALU merge
// Sums lane products for dot and squares, then a pipelined square root,
// one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module v3a_merge
  import v3a_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 adv_i,
  input  wire op_e                  op1_i,
  input  wire prod_t                p0_i [3],
  input  wire prod_t                p1_i [3],
  output logic [RootWidth-1:0]      m_o,
  output logic                      m_vld_o,
  output lane_ctl_t                 ctl_o
);

  // stage 2: dot / sum of squares (p1 carries a_i*a_i from the lanes)
  lane_ctl_t c2_q;
  logic [SqWidth-1:0] sq_w;
  data_t dot_w;
  logic  ovd_w;

  always_comb begin
    sq_w  = SqWidth'(p1_i[0]) + SqWidth'(p1_i[1]) + SqWidth'(p1_i[2]);
    dot_w = sat_sum(round_frac(SumWidth'(p0_i[0]) + SumWidth'(p0_i[1]) +
                               SumWidth'(p0_i[2])), ovd_w);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      c2_q.op <= op1_i;
      c2_q.a  <= '0;
      c2_q.r  <= (op1_i == OP_DOT) ? dot_w : '0;
      c2_q.ov <= (op1_i == OP_DOT) ? ovd_w : 1'b0;
      c2_q.sq <= sq_w;
    end
  end

  // square root, digit recurrence over RootWidth stages
  localparam int RemW = RootWidth + 2;
  logic [SqWidth-1:0]   x_q [RootWidth+1];
  logic [RemW-1:0]      rm_q[RootWidth+1];
  logic [RootWidth-1:0] rt_q[RootWidth+1];
  lane_ctl_t            c_q [RootWidth+1];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q[0]  <= c2_q.sq;
      rm_q[0] <= '0;
      rt_q[0] <= '0;
      c_q[0]  <= c2_q;
    end
  end

  for (genvar k = 0; k < RootWidth; k++) begin : g_sqrt
    logic [RemW-1:0] t_w;
    logic [RemW-1:0] tr_w;
    assign t_w  = {rm_q[k][RemW-3:0], x_q[k][SqWidth-1 -: 2]};
    assign tr_w = {rt_q[k], 2'b01};
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        x_q[k+1] <= x_q[k] << 2;
        c_q[k+1] <= c_q[k];
        if (t_w >= tr_w) begin
          rm_q[k+1] <= t_w - tr_w;
          rt_q[k+1] <= {rt_q[k][RootWidth-2:0], 1'b1};
        end else begin
          rm_q[k+1] <= t_w;
          rt_q[k+1] <= {rt_q[k][RootWidth-2:0], 1'b0};
        end
      end
    end
  end

  // round: s - r^2 > r  <=>  rem > r
  logic [RootWidth-1:0] rf_w;
  always_comb begin
    rf_w = rt_q[RootWidth];
    if (rm_q[RootWidth] > RemW'(rt_q[RootWidth])) begin
      rf_w = rf_w + 1'b1;
    end
  end

  lane_ctl_t cm_w;
  data_t     mags_w;
  logic      ovm_w;

  always_comb begin
    mags_w = sat_sum(SumWidth'(rf_w), ovm_w);
    cm_w   = c_q[RootWidth];
    if (c_q[RootWidth].op == OP_MAG) begin
      cm_w.r  = mags_w;
      cm_w.ov = ovm_w;
    end
  end

  assign m_o     = rf_w;
  assign m_vld_o = (c_q[RootWidth].sq != '0);

  // carry scalar through the divider stages
  lane_ctl_t cd_q [QuoWidth+1];
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cd_q[0] <= cm_w;
      for (int i = 1; i <= QuoWidth; i++) begin
        cd_q[i] <= cd_q[i-1];
      end
    end
  end
  assign ctl_o = cd_q[QuoWidth];

endmodule

`default_nettype wire

// ===== sv/vector3_arithmetic_unit_top.sv =====
// Pipeline depth is set by the square root and divider step pipelines that
// lie between the input beat and the output beat.
// Throughput: one beat per cycle; the pipeline advances whenever the output
// register is empty or being taken.
// Reset: rst_ni clears only the valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// Vector ALU top
// Three component lanes plus a merge stage for dot, magnitude and normalize.
// ----------------------------------------------------------------------------
`default_nettype none

module vector3_arithmetic_unit_top
  import v3a_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [OpWidth-1:0]    operation_i,
  input  wire data_t                 ax_i,
  input  wire data_t                 ay_i,
  input  wire data_t                 az_i,
  input  wire data_t                 bx_i,
  input  wire data_t                 by_i,
  input  wire data_t                 bz_i,
  input  wire data_t                 factor_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output data_t                      rx_o,
  output data_t                      ry_o,
  output data_t                      rz_o,
  output data_t                      scalar_out_o,
  output logic                       overflow_o,
  output logic                       zero_length_o
);

  `include "vector3_arithmetic_unit_top_assert.svh"

  localparam int Lat = PipeDepth;

  logic           adv;
  logic [Lat-1:0] vld_q;
  op_e            op_w;
  op_e            op1_q;

  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;
  assign op_w       = op_e'(operation_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op1_q <= op_w;
    end
  end

  data_t a_w [3];
  data_t b_w [3];
  assign a_w[0] = ax_i; assign a_w[1] = ay_i; assign a_w[2] = az_i;
  assign b_w[0] = bx_i; assign b_w[1] = by_i; assign b_w[2] = bz_i;

  prod_t                p0 [3];
  prod_t                p1 [3];
  data_t                lr [3];
  logic                 lov [3];
  logic [RootWidth-1:0] m;
  logic                 m_vld;
  lane_ctl_t            ctl;

  // lane i: p0 = cross first term or dot/scale, p1 = cross second term, scale or a*a
  for (genvar i = 0; i < 3; i++) begin : g_lane
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    data_t c_w, d_w, f_w, g_w;
    always_comb begin
      if (op_w == OP_CRS) begin
        c_w = a_w[J]; d_w = b_w[K]; f_w = a_w[K]; g_w = b_w[J];
      end else if (op_w == OP_SCL) begin
        c_w = a_w[i]; d_w = b_w[i]; f_w = factor_i; g_w = a_w[i];
      end else begin
        c_w = a_w[i]; d_w = b_w[i]; f_w = a_w[i]; g_w = a_w[i];
      end
    end
    v3a_lane u_lane (
      .clk_i   (clk_i),
      .adv_i   (adv),
      .op_i    (op_w),
      .a_i     (a_w[i]),
      .b_i     (b_w[i]),
      .c_i     (c_w),
      .d_i     (d_w),
      .f_i     (f_w),
      .g_i     (g_w),
      .m_i     (m),
      .m_vld_i (m_vld),
      .p0_o    (p0[i]),
      .p1_o    (p1[i]),
      .r_o     (lr[i]),
      .ov_o    (lov[i])
    );
  end

  v3a_merge u_merge (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .op1_i   (op1_q),
    .p0_i    (p0),
    .p1_i    (p1),
    .m_o     (m),
    .m_vld_o (m_vld),
    .ctl_o   (ctl)
  );

  logic vec_op;
  assign vec_op = !(ctl.op == OP_DOT || ctl.op == OP_MAG);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= vld_q[Lat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rx_o          <= vec_op ? lr[0] : '0;
      ry_o          <= vec_op ? lr[1] : '0;
      rz_o          <= vec_op ? lr[2] : '0;
      scalar_out_o  <= vec_op ? '0 : ctl.r;
      overflow_o    <= vec_op ? (lov[0] | lov[1] | lov[2]) : ctl.ov;
      zero_length_o <= (ctl.op == OP_NRM) && (ctl.sq == '0);
    end
  end

  `V3A_ASSERT_IMPL(a_stall_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                   in_stall_o, "input taken while output stalled")
  `V3A_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                   out_valid_o, "stalled output beat dropped")
  `V3A_ASSERT_IMPL(a_zl_clean, clk_i, rst_ni, out_valid_o && zero_length_o,
                   !overflow_o && rx_o == '0, "zero length with nonzero result")

endmodule

`default_nettype wire

// ===== dv/vector3_arithmetic_unit_top_tb.sv =====
// ----------------------------------------------------------------------------
// Vector ALU testbench
// Drives add, sub, negate, scale, dot, cross, magnitude and normalize beats
// through the unit under random idle and stall patterns; compares every beat
// field by field to a bit-exact fixed-point predictor or a fixed result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module vector3_arithmetic_unit_top_tb;
  import v3a_pkg::*;

  typedef logic signed [79:0] wide_t;
  typedef logic [79:0] uwide_t;

  typedef struct {
    op_e   op;
    data_t ax, ay, az, bx, by, bz, factor;
  } vec_req_t;

  typedef struct {
    data_t rx, ry, rz, sc;
    logic  ov, zl;
  } vec_res_t;

  typedef struct {
    vec_req_t req;
    bit       fixed;
    vec_res_t res;
  } dir_row_t;

  localparam wide_t WideMax = 80'sd2147483647;
  localparam wide_t WideMin = -80'sd2147483648;
  localparam data_t DMax = 32'sh7fffffff;
  localparam data_t DMin = 32'sh80000000;
  localparam data_t One = 32'sh00010000;
  localparam int WatchLimit = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [OpWidth-1:0] operation_i = '0;
  data_t ax_i = '0, ay_i = '0, az_i = '0, bx_i = '0, by_i = '0, bz_i = '0;
  data_t factor_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  data_t rx_o, ry_o, rz_o, scalar_out_o;
  logic overflow_o, zero_length_o;

  vector3_arithmetic_unit_top uut (.*);

  vec_res_t result_q[$];
  dir_row_t dir_rows[$];
  int mismatches = 0;
  int beats_in = 0;
  int beats_out = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int idle_cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic data_t clamp(input wide_t x, inout logic ov);
    if (x > WideMax) begin
      ov = 1'b1;
      return DMax;
    end
    if (x < WideMin) begin
      ov = 1'b1;
      return DMin;
    end
    return data_t'(x);
  endfunction

  function automatic wide_t round_q(input wide_t x);
    return (x + 80'sd32768) >>> FracBits;
  endfunction

  function automatic wide_t prod(input data_t p, input data_t q);
    return wide_t'(p) * wide_t'(q);
  endfunction

  function automatic uwide_t mag_of(input wide_t v);
    return uwide_t'(v < 0 ? -v : v);
  endfunction

  function automatic vec_res_t predict_vec(input vec_req_t q);
    vec_res_t o;
    data_t a[3];
    uwide_t s, r, t, m, num, quo;
    wide_t v;
    logic ov;
    a[0] = q.ax;
    a[1] = q.ay;
    a[2] = q.az;
    o = '{default: '0};
    ov = 1'b0;
    case (q.op)
      OP_ADD: begin
        o.rx = clamp(wide_t'(q.ax) + wide_t'(q.bx), ov);
        o.ry = clamp(wide_t'(q.ay) + wide_t'(q.by), ov);
        o.rz = clamp(wide_t'(q.az) + wide_t'(q.bz), ov);
      end
      OP_SUB: begin
        o.rx = clamp(wide_t'(q.ax) - wide_t'(q.bx), ov);
        o.ry = clamp(wide_t'(q.ay) - wide_t'(q.by), ov);
        o.rz = clamp(wide_t'(q.az) - wide_t'(q.bz), ov);
      end
      OP_NEG: begin
        o.rx = clamp(-wide_t'(q.ax), ov);
        o.ry = clamp(-wide_t'(q.ay), ov);
        o.rz = clamp(-wide_t'(q.az), ov);
      end
      OP_SCL: begin
        o.rx = clamp(round_q(prod(q.ax, q.factor)), ov);
        o.ry = clamp(round_q(prod(q.ay, q.factor)), ov);
        o.rz = clamp(round_q(prod(q.az, q.factor)), ov);
      end
      OP_DOT: begin
        o.sc = clamp(round_q(prod(q.ax, q.bx) + prod(q.ay, q.by) + prod(q.az, q.bz)), ov);
      end
      OP_CRS: begin
        o.rx = clamp(round_q(prod(q.ay, q.bz) - prod(q.az, q.by)), ov);
        o.ry = clamp(round_q(prod(q.az, q.bx) - prod(q.ax, q.bz)), ov);
        o.rz = clamp(round_q(prod(q.ax, q.by) - prod(q.ay, q.bx)), ov);
      end
      default: begin
        s = '0;
        for (int i = 0; i < 3; i++) s += mag_of(a[i]) * mag_of(a[i]);
        r = '0;
        for (int i = 39; i >= 0; i--) begin
          t = r | (uwide_t'(1) << i);
          if (t * t <= s) r = t;
        end
        if (s - r * r > r) r++;
        m = r;
        if (q.op == OP_MAG) begin
          o.sc = clamp(wide_t'(m), ov);
        end else if (s == 0) begin
          o.zl = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            num = mag_of(a[i]) << FracBits;
            quo = (num + (m >> 1)) / m;
            v = a[i] < 0 ? -wide_t'(quo) : wide_t'(quo);
            if (i == 0) o.rx = clamp(v, ov);
            else if (i == 1) o.ry = clamp(v, ov);
            else o.rz = clamp(v, ov);
          end
        end
      end
    endcase
    o.ov = ov;
    return o;
  endfunction

  function automatic data_t rand_operand();
    case ($urandom_range(9))
      0: return DMax;
      1: return DMin;
      2: return '0;
      3, 4: return data_t'($urandom);
      5, 6: return data_t'($urandom_range(32'h0003ffff)) - 32'sh00020000;
      default: return data_t'($urandom_range(32'h01ffffff)) - 32'sh01000000;
    endcase
  endfunction

  function automatic vec_req_t rand_req();
    vec_req_t q;
    q.op = op_e'($urandom_range(7));
    q.ax = rand_operand();
    q.ay = rand_operand();
    q.az = rand_operand();
    q.bx = rand_operand();
    q.by = rand_operand();
    q.bz = rand_operand();
    q.factor = rand_operand();
    if ($urandom_range(19) == 0) begin
      q.ax = '0;
      q.ay = '0;
      q.az = '0;
    end
    return q;
  endfunction

  function automatic void add_row(input op_e op, input data_t ax, ay, az, bx, by, bz, f,
                                  input bit fixed = 0, input vec_res_t res = '{default: '0});
    dir_row_t d;
    d.req = '{op, ax, ay, az, bx, by, bz, f};
    d.fixed = fixed;
    d.res = res;
    dir_rows.push_back(d);
  endfunction

  task automatic send_beat(input vec_req_t q, input bit fixed, input vec_res_t res);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= q.op;
    ax_i <= q.ax;
    ay_i <= q.ay;
    az_i <= q.az;
    bx_i <= q.bx;
    by_i <= q.by;
    bz_i <= q.bz;
    factor_i <= q.factor;
    do @(posedge clk_i); while (in_stall_o);
    result_q.push_back(fixed ? res : predict_vec(q));
    beats_in++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(input int n, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    for (int i = 0; i < n; i++) send_beat(rand_req(), 1'b0, '{default: '0});
    drain();
  endtask

  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      out_stall_i <= 1'b1;
      hold_req <= hold_req - 1;
    end else begin
      out_stall_i <= recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog: no beat for %0d cycles, %0d results pending",
               WatchLimit, result_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    vec_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_out++;
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat rx=%h", rx_o);
      end else begin
        e = result_q.pop_front();
        if (e.rx !== rx_o || e.ry !== ry_o || e.rz !== rz_o || e.sc !== scalar_out_o
            || e.ov !== overflow_o || e.zl !== zero_length_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: exp r=%h %h %h s=%h ov=%b zl=%b, got r=%h %h %h s=%h ov=%b zl=%b",
                     beats_out, e.rx, e.ry, e.rz, e.sc, e.ov, e.zl,
                     rx_o, ry_o, rz_o, scalar_out_o, overflow_o, zero_length_o);
        end
      end
    end
  end

  initial begin
    add_row(OP_ADD, 0, 0, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 0});
    add_row(OP_ADD, DMax, DMax, 1, DMax, 1, -1, 0, 1, '{DMax, DMax - 1 + 1, 0, 0, 1, 0});
    add_row(OP_SUB, DMin, DMax, 5, DMax, DMin, 7, 0, 1, '{DMin, DMax, -2, 0, 1, 0});
    add_row(OP_NEG, DMin, DMax, 0, DMax, DMax, DMax, DMax, 1, '{DMax, DMin + 1, 0, 0, 1, 0});
    add_row(OP_NEG, 1, -1, 32'sh12345678, 0, 0, 0, 0);
    add_row(OP_SCL, One, -One, 3, 0, 0, 0, 32'sh00008000);
    add_row(OP_SCL, DMax, DMin, 1, 0, 0, 0, DMax);
    add_row(OP_SCL, DMin, DMin, DMin, 0, 0, 0, DMin);
    add_row(OP_DOT, One, 2 * One, 3 * One, 4 * One, 5 * One, 6 * One, 0);
    add_row(OP_DOT, DMax, DMax, DMax, DMax, DMax, DMax, 0, 1, '{0, 0, 0, DMax, 1, 0});
    add_row(OP_DOT, DMin, DMin, DMin, DMax, DMax, DMax, 0, 1, '{0, 0, 0, DMin, 1, 0});
    add_row(OP_CRS, One, 0, 0, 0, One, 0, 0);
    add_row(OP_CRS, DMax, DMin, DMax, DMin, DMax, DMin, 0);
    add_row(OP_MAG, 0, 0, 0, DMax, DMax, DMax, DMax, 1, '{0, 0, 0, 0, 0, 0});
    add_row(OP_MAG, 3 * One, 4 * One, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 5 * One, 0, 0});
    add_row(OP_MAG, DMin, DMin, DMin, 0, 0, 0, 0, 1, '{0, 0, 0, DMax, 1, 0});
    add_row(OP_MAG, 1, 1, 1, 0, 0, 0, 0);
    add_row(OP_NRM, 0, 0, 0, DMax, DMin, 1, DMax, 1, '{0, 0, 0, 0, 0, 1});
    add_row(OP_NRM, 3 * One, -4 * One, 0, 0, 0, 0, 0);
    add_row(OP_NRM, DMin, 0, 0, 0, 0, 0, 0);
    add_row(OP_NRM, 1, 0, 0, 0, 0, 0, 0);
    add_row(OP_NRM, DMax, DMin, DMax, 0, 0, 0, 0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_beat(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].res);
    drain();

    run_random(180, 0, 0);
    run_random(160, 78, 0);
    run_random(160, 0, 78);
    run_random(160, 22, 22);

    // hold the output side long enough for the pipe to fill and back up
    hold_req = 400;
    run_random(140, 0, 0);

    @(posedge clk_i);
    in_valid_i <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);

    $display("covered all eight operations with saturation, zero-length and rounding cases");
    $display("%0d beats in, %0d beats out, %0d mismatches", beats_in, beats_out, mismatches);
    if (mismatches == 0 && result_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/v3a_pkg.sv
sv/v3a_lane.sv
sv/v3a_merge.sv
sv/vector3_arithmetic_unit_top.sv
dv/vector3_arithmetic_unit_top_tb.sv
